// ----- design/grid_edge_visible_cell_query_defines.svh -----
// ----------------------------------------------------------------------------
// grid edge visibility query: assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef GRID_EDGE_VISIBLE_CELL_QUERY_DEFINES_SVH
`define GRID_EDGE_VISIBLE_CELL_QUERY_DEFINES_SVH

// same-cycle implication, quiet during reset
`define GEVC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define GEVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/gevc_pkg.sv -----
// ----------------------------------------------------------------------------
// gevc_pkg
// shared types and constants of the grid edge visibility query block
// ----------------------------------------------------------------------------
package gevc_pkg;

    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int ROW_W       = 6;
    localparam int COL_W       = 6;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // sequencer to scan unit
    typedef struct packed {
        logic load_row;
        logic scan_step;
    } scan_ctrl_t;

    // scan unit to sequencer
    typedef struct packed {
        logic opaque;
        logic visible;
    } scan_res_t;

endpackage

// ----- design/gevc_ram.sv -----
// ----------------------------------------------------------------------------
// gevc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module gevc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/gevc_scan.sv -----
// ----------------------------------------------------------------------------
// gevc_scan
// shared compare unit: row edge checks, then one column bit per scanned row
// ----------------------------------------------------------------------------
module gevc_scan #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64,
    parameter int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    parameter int COL_AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  gevc_pkg::scan_ctrl_t       ctrl,
    input  logic [MAX_COLS-1:0]        word,
    input  logic [COL_AW-1:0]          col,
    input  logic [ROW_AW-1:0]          row,
    input  logic [ROW_AW-1:0]          idx,
    input  logic [gevc_pkg::CFG_W-1:0] used_cols,
    output gevc_pkg::scan_res_t        res
);

    import gevc_pkg::*;

    logic [MAX_COLS-1:0] lo_mask;
    logic [MAX_COLS-1:0] hi_mask;
    logic                hit;
    logic                opaque_reg;
    logic                left_reg;
    logic                right_reg;
    logic                top_reg;
    logic                bot_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_COLS; i++)
        begin
            lo_mask[i] = (i < int'(col));
            hi_mask[i] = (i > int'(col)) && (i < int'(used_cols));
        end
    end

    assign hit = word[col];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opaque_reg <= 1'b0;
            left_reg   <= 1'b0;
            right_reg  <= 1'b0;
            top_reg    <= 1'b0;
            bot_reg    <= 1'b0;
        end
        else if (ctrl.load_row)
        begin
            opaque_reg <= hit;
            left_reg   <= |(word & lo_mask);
            right_reg  <= |(word & hi_mask);
            top_reg    <= 1'b0;
            bot_reg    <= 1'b0;
        end
        else if (ctrl.scan_step && hit && (idx != row))
        begin
            if (idx < row)
            begin
                top_reg <= 1'b1;
            end
            else
            begin
                bot_reg <= 1'b1;
            end
        end
    end

    assign res.opaque  = opaque_reg;
    assign res.visible = opaque_reg && (!top_reg || !bot_reg || !left_reg || !right_reg);

endmodule

// ----- design/grid_edge_visible_cell_query.sv -----
// ----------------------------------------------------------------------------
// grid_edge_visible_cell_query
// binary grid store answering whether a cell is seen first from an edge
// ----------------------------------------------------------------------------
// The grid sits in one ram, one row word per address, with a valid bit per
// row so reset clears it at once and no clearing pass runs. A write item
// steps through accept with row read, then merge and row write back; a
// write outside the configured size is dropped at accept. A read item steps
// through accept, row read, one scan step per row in use through the single
// ram read port, and result load before its result is offered; an out of
// range read goes from accept straight to result load. A result still
// waiting in the output register holds the block in its result load state.
// Only one item is in flight; the input is ready again once the result sits
// in the output register.
module grid_edge_visible_cell_query #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // row_index[5:0], col_index[11:6], cell_opaque[12], zero fill
    input  logic [gevc_pkg::S_TDATA_W-1:0] s_tdata,
    // command
    input  logic                           s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // was_opaque[0], is_visible[1], value_after[2], out_of_range[3], zero fill
    output logic [gevc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gevc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gevc_pkg::CFG_W-1:0]     cfg_data
);

    import gevc_pkg::*;

    `include "grid_edge_visible_cell_query_defines.svh"

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RN_W   = $clog2(MAX_ROWS + 1);
    localparam int CMP_W  = (RN_W > CFG_W) ? RN_W : CFG_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROW  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                state_reg;
    state_t                state_next;

    logic [CFG_W-1:0]      grid_rows_reg;
    logic [CFG_W-1:0]      grid_cols_reg;
    logic [CMP_W-1:0]      used_rows;
    logic [CFG_W-1:0]      used_cols;

    logic [ROW_W-1:0]      in_row;
    logic [COL_W-1:0]      in_col;
    logic                  in_val;
    logic                  in_bounds;
    logic                  in_accept;

    logic                  cmd_reg;
    logic [ROW_AW-1:0]     row_reg;
    logic [COL_AW-1:0]     col_reg;
    logic                  val_reg;
    logic                  oor_reg;
    logic [ROW_AW-1:0]     last_row_reg;
    logic [ROW_AW-1:0]     rd_tag_reg;
    logic [ROW_AW-1:0]     rd_tag_next;
    logic [MAX_ROWS-1:0]   row_valid_reg;

    logic                  rd_en;
    logic [ROW_AW-1:0]     rd_addr;
    logic [MAX_COLS-1:0]   rd_data;
    logic [MAX_COLS-1:0]   word_eff;
    logic                  wr_en;
    logic [MAX_COLS-1:0]   wr_data;

    scan_ctrl_t            scan_ctrl;
    scan_res_t             scan_res;

    logic                  out_load;
    logic                  out_valid_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= CFG_W'(64);
            grid_cols_reg <= CFG_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                REG_GRID_COLS: grid_cols_reg <= cfg_data;
                default:       grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    assign used_rows = (CMP_W'(grid_rows_reg) > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS)
                                                                  : CMP_W'(grid_rows_reg);
    assign used_cols = (grid_cols_reg > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : grid_cols_reg;

    // input item
    assign in_row    = s_tdata[ROW_W-1:0];
    assign in_col    = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_val    = s_tdata[ROW_W+COL_W];
    assign in_bounds = (CMP_W'(in_row) < used_rows) && (CFG_W'(in_col) < used_cols);
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // rows never written read as zero
    assign word_eff = row_valid_reg[rd_tag_reg] ? rd_data : '0;

    always_comb
    begin
        wr_data          = word_eff;
        wr_data[col_reg] = val_reg;
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    // sequencer
    always_comb
    begin
        state_next          = state_reg;
        rd_en               = 1'b0;
        rd_addr             = rd_tag_reg;
        rd_tag_next         = rd_tag_reg;
        wr_en               = 1'b0;
        scan_ctrl.load_row  = 1'b0;
        scan_ctrl.scan_step = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_bounds)
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = ROW_AW'(in_row);
                        rd_tag_next = ROW_AW'(in_row);
                        state_next  = S_ROW;
                    end
                    else if (s_tuser == CMD_READ)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ROW:
            begin
                if (cmd_reg == CMD_WRITE)
                begin
                    wr_en      = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_ctrl.load_row = 1'b1;
                    rd_en              = 1'b1;
                    rd_addr            = '0;
                    rd_tag_next        = '0;
                    state_next         = S_SCAN;
                end
            end
            S_SCAN:
            begin
                scan_ctrl.scan_step = 1'b1;
                if (rd_tag_reg == last_row_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr     = rd_tag_reg + ROW_AW'(1);
                    rd_tag_next = rd_tag_reg + ROW_AW'(1);
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_tag_reg    <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_tag_reg <= rd_tag_next;
            if (wr_en)
            begin
                row_valid_reg[row_reg] <= 1'b1;
            end
        end
    end

    // item fields, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg      <= s_tuser;
            row_reg      <= ROW_AW'(in_row);
            col_reg      <= COL_AW'(in_col);
            val_reg      <= in_val;
            oor_reg      <= !in_bounds;
            last_row_reg <= ROW_AW'(used_rows - CMP_W'(1));
        end
    end

    gevc_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (row_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gevc_scan #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .word      (word_eff),
        .col       (col_reg),
        .row       (row_reg),
        .idx       (rd_tag_reg),
        .used_cols (used_cols),
        .res       (scan_res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (oor_reg)
            begin
                out_data_reg <= M_TDATA_W'(4'b1000);
            end
            else
            begin
                out_data_reg <= M_TDATA_W'({1'b0,
                                            scan_res.opaque && !scan_res.visible,
                                            scan_res.visible,
                                            scan_res.opaque});
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `GEVC_ASSERT_IMP(a_oor_fields_zero, m_tvalid && m_tdata[3], m_tdata[2:0] == 3'b000, "out of range item carries cell flags")
    `GEVC_ASSERT_IMP(a_after_needs_opaque, m_tvalid && (m_tdata[2] || m_tdata[1]), m_tdata[0] && !(m_tdata[2] && m_tdata[1]), "visibility flags inconsistent with stored value")
    `GEVC_ASSERT_IMP(a_scan_only_read, state_reg == S_SCAN, cmd_reg == CMD_READ && !oor_reg, "scan running for a write or out of range item")
    `GEVC_ASSERT_NEXT(a_write_back_ends, state_reg == S_ROW && cmd_reg == CMD_WRITE, state_reg == S_IDLE && row_valid_reg[row_reg], "write back did not mark row valid")

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the grid edge visibility query block: a queue-fed
// driver and a monitor run against a software copy of the grid, over several
// grid sizes, with random gaps and stalls on both streams
// ----------------------------------------------------------------------------
module tb_top;

    import gevc_pkg::*;

    localparam int GRID_MAX = 64;

    typedef struct packed {
        logic       cmd;
        logic [5:0] row;
        logic [5:0] col;
        logic       opaque;
    } cell_op_t;

    // was_opaque sits in bit 0, as on m_tdata
    typedef struct packed {
        logic out_of_range;
        logic value_after;
        logic is_visible;
        logic was_opaque;
    } cell_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // shadow grid and size registers
    logic [63:0]  grid_mem [0:GRID_MAX-1] = '{default: '0};
    logic [6:0]   rows_cfg = 7'd64;
    logic [6:0]   cols_cfg = 7'd64;

    cell_op_t     pending_ops [$];
    cell_report_t visibility_due [$];
    cell_op_t     cur_op;
    cell_op_t     taken_op;
    cell_report_t due;

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    logic cfg_taken = 1'b0;
    logic src_next;
    bit   src_idle_on = 1'b1;
    bit   sink_idle_on = 1'b1;
    int   src_gap = 0;
    int   sink_wait = 0;
    int   ops_queued = 0;
    int   ops_accepted = 0;
    int   results_seen = 0;
    int   fails = 0;
    int   fi;

    string report_fields [4] = '{"was_opaque", "is_visible", "value_after", "out_of_range"};

    grid_edge_visible_cell_query DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // applies one accepted item to the shadow grid, queues the report of a read
    task automatic predict_cell_op(input cell_op_t op);
        int           nrows;
        int           ncols;
        int           r;
        logic [63:0]  word;
        logic [63:0]  colmask;
        logic [63:0]  left_bits;
        logic [63:0]  right_bits;
        logic         up;
        logic         down;
        logic         in_grid;
        cell_report_t rep;
        nrows = (rows_cfg > GRID_MAX) ? GRID_MAX : rows_cfg;
        ncols = (cols_cfg > GRID_MAX) ? GRID_MAX : cols_cfg;
        in_grid = (op.row < nrows) && (op.col < ncols);
        rep = '0;
        if (op.cmd == CMD_WRITE)
        begin
            if (in_grid)
                grid_mem[op.row][op.col] = op.opaque;
        end
        else
        begin
            if (!in_grid)
                rep.out_of_range = 1'b1;
            else
            begin
                word = grid_mem[op.row];
                colmask = (ncols >= 64) ? {64{1'b1}} : ((64'd1 << ncols) - 64'd1);
                left_bits = word & ((64'd1 << op.col) - 64'd1);
                right_bits = word & colmask & ~((64'd2 << op.col) - 64'd1);
                up = 1'b0;
                down = 1'b0;
                for (r = 0; r < nrows; r++)
                begin
                    if (r != op.row && grid_mem[r][op.col])
                    begin
                        if (r < op.row)
                            up = 1'b1;
                        else
                            down = 1'b1;
                    end
                end
                rep.was_opaque = word[op.col];
                rep.is_visible = word[op.col]
                    && (!up || !down || left_bits == '0 || right_bits == '0);
                rep.value_after = rep.was_opaque && !rep.is_visible;
            end
            visibility_due.push_back(rep);
        end
    endtask

    // monitor and predictor
    always @(posedge clk)
    begin
        in_taken <= s_tvalid && s_tready;
        out_taken <= m_tvalid && m_tready;
        cfg_taken <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GRID_ROWS)
                    rows_cfg = cfg_data;
                else if (cfg_index == REG_GRID_COLS)
                    cols_cfg = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                taken_op.cmd = s_tuser;
                taken_op.row = s_tdata[5:0];
                taken_op.col = s_tdata[11:6];
                taken_op.opaque = s_tdata[12];
                ops_accepted++;
                predict_cell_op(taken_op);
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (visibility_due.size() == 0)
                begin
                    $error("result %h with nothing expected", m_tdata);
                    fails++;
                end
                else
                begin
                    due = visibility_due.pop_front();
                    for (fi = 0; fi < 4; fi++)
                    begin
                        if (m_tdata[fi] !== due[fi])
                        begin
                            $error("%s expected %0b actual %0b",
                                   report_fields[fi], due[fi], m_tdata[fi]);
                            fails++;
                        end
                    end
                end
            end
        end
    end

    // input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            src_next = s_tvalid && !in_taken;
            if (in_taken)
                src_gap = src_idle_on ? $urandom_range(0, 4) : 0;
            if (!src_next)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (pending_ops.size() != 0)
                begin
                    cur_op = pending_ops.pop_front();
                    s_tdata <= {3'b000, cur_op.opaque, cur_op.col, cur_op.row};
                    s_tuser <= cur_op.cmd;
                    src_next = 1'b1;
                end
            end
            s_tvalid <= src_next;
        end
    end

    // result sink, with two long hold-offs to back the block up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (m_tready && out_taken)
            begin
                if (results_seen == 40 || results_seen == 250)
                    sink_wait = 400;
                else
                    sink_wait = sink_idle_on ? $urandom_range(0, 4) : 0;
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic queue_op(input logic cmd, input int row, input int col, input logic opq);
        cell_op_t op;
        op.cmd = cmd;
        op.row = row[5:0];
        op.col = col[5:0];
        op.opaque = opq;
        pending_ops.push_back(op);
        ops_queued++;
    endtask

    task automatic wait_drained(input int settle);
        do
            @(negedge clk);
        while (ops_accepted != ops_queued || visibility_due.size() != 0);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_W-1:0];
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid_size(input int nrows, input int ncols);
        wait_drained(8);
        write_reg(REG_GRID_ROWS, nrows);
        write_reg(REG_GRID_COLS, ncols);
        @(posedge clk);
    endtask

    // random items clustered in a small window so hidden cells show up
    task automatic random_phase(input int nrows, input int ncols, input int n_items,
                                input int win, input bit calm);
        int er;
        int ec;
        int wr;
        int wc;
        int br;
        int bc;
        int k;
        int sel;
        int r;
        int c;
        set_grid_size(nrows, ncols);
        src_idle_on = !calm && ($urandom_range(0, 3) != 0);
        sink_idle_on = !calm && ($urandom_range(0, 3) != 0);
        er = (nrows > GRID_MAX) ? GRID_MAX : nrows;
        ec = (ncols > GRID_MAX) ? GRID_MAX : ncols;
        wr = (er == 0) ? 1 : ((er < win) ? er : win);
        wc = (ec == 0) ? 1 : ((ec < win) ? ec : win);
        br = (er > wr) ? $urandom_range(0, er - wr) : 0;
        bc = (ec > wc) ? $urandom_range(0, ec - wc) : 0;
        for (k = 0; k < n_items; k++)
        begin
            sel = $urandom_range(0, 9);
            r = br + $urandom_range(0, wr - 1);
            c = bc + $urandom_range(0, wc - 1);
            if (sel == 8)
            begin
                r = $urandom_range(0, 63);
                c = $urandom_range(0, 63);
            end
            else if (sel == 9)
            begin
                if (er < GRID_MAX)
                    r = $urandom_range(er, 63);
                if (ec < GRID_MAX && $urandom_range(0, 1) == 1)
                    c = $urandom_range(ec, 63);
            end
            queue_op(($urandom_range(0, 99) < 45) ? CMD_READ : CMD_WRITE, r, c,
                     $urandom_range(0, 99) < 70);
        end
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        // empty grid, corners, a fully enclosed cell and its release
        queue_op(CMD_READ, 0, 0, 1'b0);
        queue_op(CMD_WRITE, 0, 0, 1'b1);
        queue_op(CMD_READ, 0, 0, 1'b0);
        queue_op(CMD_WRITE, 63, 63, 1'b1);
        queue_op(CMD_READ, 63, 63, 1'b1);
        queue_op(CMD_WRITE, 9, 10, 1'b1);
        queue_op(CMD_WRITE, 11, 10, 1'b1);
        queue_op(CMD_WRITE, 10, 9, 1'b1);
        queue_op(CMD_WRITE, 10, 11, 1'b1);
        queue_op(CMD_WRITE, 10, 10, 1'b1);
        queue_op(CMD_READ, 10, 10, 1'b0);
        queue_op(CMD_READ, 9, 10, 1'b0);
        queue_op(CMD_WRITE, 10, 11, 1'b0);
        queue_op(CMD_READ, 10, 10, 1'b1);
        queue_op(CMD_WRITE, 0, 0, 1'b0);
        queue_op(CMD_READ, 0, 0, 1'b1);

        // shrunken rows, columns above the maximum
        set_grid_size(3, 127);
        queue_op(CMD_READ, 10, 10, 1'b0);
        queue_op(CMD_WRITE, 5, 5, 1'b1);
        queue_op(CMD_READ, 2, 63, 1'b0);
        queue_op(CMD_WRITE, 2, 40, 1'b1);
        queue_op(CMD_READ, 2, 40, 1'b0);

        random_phase(64, 64, 120, 6, 1'b0);
        random_phase(1, 1, 30, 1, 1'b0);
        random_phase(0, 12, 30, 4, 1'b0);
        random_phase(127, 64, 80, 8, 1'b0);
        random_phase(5, 7, 80, 8, 1'b0);
        random_phase(64, 1, 50, 6, 1'b0);
        random_phase(2, 127, 50, 6, 1'b0);
        random_phase(13, 0, 30, 5, 1'b0);
        random_phase(64, 64, 70, 4, 1'b1);
        random_phase(8, 8, 60, 8, 1'b0);

        wait_drained(80);
        if (fails == 0 && visibility_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/gevc_pkg.sv
design/gevc_ram.sv
design/gevc_scan.sv
design/grid_edge_visible_cell_query.sv
tb/tb_top.sv
